// ===== rtl/countdown_timer_bank_assert.svh =====
// Assertion macros used by the countdown timer bank top level.
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CTB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CTB_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CTB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/ctb_pkg.sv =====
// Types and constants shared by the countdown timer bank modules.
package ctb_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int COUNT_WIDTH  = 32;
   localparam int CHAN_WIDTH   = 5;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [CHAN_WIDTH-1:0]   chan_type;
   typedef logic [NUM_CHANNELS-1:0] mask_type;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_REGISTER = 2'd1,
      CMD_ALLOCATE = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   // One command and its partial result as it travels down the chain of cells.
   typedef struct packed {
      logic      valid;
      cmd_type   cmd;
      chan_type  channel;
      count_type period;
      logic      handler_present;
      logic      accepted;
      logic      found;
      chan_type  found_channel;
      logic      is_free;
      mask_type  fired;
   } link_type;

endpackage

// ===== rtl/ctb_cell.sv =====
// One timer channel: its count and flag bits, acting on the command passing by.
module ctb_cell
   import ctb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  chan_type cell_index,
   input  logic     hold,
   input  link_type link_in,
   output link_type link_out
);

   count_type count_ff, count_in;
   logic      active_ff, active_in;
   logic      armed_ff, armed_in;
   logic      handler_ff, handler_in;
   link_type  link_ff, link_next_in;

   logic      chan_match;
   count_type count_dec;

   assign chan_match = (link_in.channel == cell_index);
   assign count_dec  = count_ff - COUNT_WIDTH'(1);

   // State update for this channel.
   always_comb begin
      count_in   = count_ff;
      active_in  = active_ff;
      armed_in   = armed_ff;
      handler_in = handler_ff;
      if (link_in.valid) begin
         case (link_in.cmd)
            CMD_TICK: begin
               if (active_ff && (count_ff != '0)) begin
                  count_in = count_dec;
               end
            end
            CMD_REGISTER: begin
               if (chan_match) begin
                  count_in   = link_in.period;
                  handler_in = link_in.handler_present;
                  active_in  = 1'b1;
               end
            end
            CMD_ALLOCATE: begin
               if (!link_in.found && !armed_ff) begin
                  armed_in   = 1'b1;
                  count_in   = '0;
                  handler_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Partial result handed to the next cell.
   always_comb begin
      link_next_in = link_in;
      if (link_in.valid) begin
         case (link_in.cmd)
            CMD_TICK: begin
               if (active_ff && handler_ff && (count_ff == COUNT_WIDTH'(1))) begin
                  link_next_in.fired = link_in.fired | (mask_type'(1) << cell_index);
               end
            end
            CMD_REGISTER: begin
               if (chan_match) begin
                  link_next_in.accepted = 1'b1;
               end
            end
            CMD_ALLOCATE: begin
               if (!link_in.found && !armed_ff) begin
                  link_next_in.found         = 1'b1;
                  link_next_in.found_channel = cell_index;
               end
            end
            CMD_QUERY: begin
               if (chan_match && (count_ff == '0)) begin
                  link_next_in.is_free = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         active_ff  <= 1'b0;
         armed_ff   <= 1'b0;
         handler_ff <= 1'b0;
         link_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         active_ff  <= active_in;
         armed_ff   <= armed_in;
         handler_ff <= handler_in;
         if (!hold) begin
            link_ff <= link_next_in;
         end
      end
   end

   assign link_out = link_ff;

endmodule

// ===== rtl/countdown_timer_bank.sv =====
// Countdown timer bank: sixteen channels kept in a chain of cells.
// A command walks the chain one cell per cycle, unless an untaken result stalls the
// chain at its end; while one is in flight, the next command is taken only as it leaves
// the end of the chain, so the block never holds more than one command.
// Synchronous reset clears every count and flag bit and empties the chain.
module countdown_timer_bank
   import ctb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // channel[4:0], period[36:5], handler_present[37]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // accepted[0], found_channel[5:1], is_free[6],
                                    // fired_mask[22:7]
);

`include "countdown_timer_bank_assert.svh"

   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   link_type chain [NUM_CHANNELS:0];
   link_type entry;
   link_type tail;
   logic     req_fire;
   logic     hold;
   logic     load;
   cmd_type  req_cmd;
   mask_type chain_valid;

   assign req_cmd = cmd_type'(req_tuser);
   assign tail    = chain[NUM_CHANNELS];
   assign hold    = tail.valid && rsp_valid_ff && !rsp_tready;
   assign load    = tail.valid && !hold;

   assign req_tready = !busy_ff || load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      entry                 = '0;
      entry.valid           = req_fire;
      entry.cmd             = req_cmd;
      entry.channel         = req_tdata[4:0];
      entry.period          = COUNT_WIDTH'(req_tdata[36:5]);
      entry.handler_present = req_tdata[37];
      if (req_cmd == CMD_ALLOCATE) begin
         entry.found_channel = CHAN_WIDTH'(NUM_CHANNELS);
      end
   end

   assign chain[0] = entry;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      ctb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CHAN_WIDTH'(i)),
         .hold       (hold),
         .link_in    (chain[i]),
         .link_out   (chain[i+1])
      );
      assign chain_valid[i] = chain[i+1].valid;
   end

   always_comb begin
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, 16'(tail.fired), tail.is_free, tail.found_channel,
                         tail.accepted};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Only one command is ever in flight along the chain.
   `CTB_ASSERT_ALWAYS(a_one_in_flight, clock, reset, $countones(chain_valid) <= 1,
                      "more than one command in the cell chain")
   // A command in the chain means the block reports busy.
   `CTB_ASSERT_SAME(a_chain_busy, clock, reset, chain_valid != '0, busy_ff,
                    "command in chain while not busy")
   // A fresh transfer in closes the input until the chain drains.
   `CTB_ASSERT_NEXT(a_accept_closes, clock, reset, req_fire, !req_tready,
                    "input still open right after a transfer")
   // A new result only comes from the end of the chain.
   `CTB_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(tail.valid),
                    "result appeared without a command leaving the chain")
   // A result's found channel never exceeds NUM_CHANNELS, the value an allocate leaves when no channel is free.
   `CTB_ASSERT_ALWAYS(a_found_range, clock, reset,
                      !rsp_tvalid || (rsp_tdata[5:1] <= CHAN_WIDTH'(NUM_CHANNELS)),
                      "found channel out of range")

endmodule
